/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 4;

  typedef logic signed [31:0] val_t;
  typedef logic [7:0]         pri_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [OCC_W-1:0]   occ_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_ENQ  = 2'd1,
    OP_DEQ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    val_t new_val;
    pri_t new_pri;
  } cell_ctrl_t;

endpackage

/* rtl/core/spq_if.sv */
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic          valid;
  logic          ready;
  logic          mode;
  spq_pkg::val_t value;
  spq_pkg::pri_t priority_req;

  modport source (output valid, mode, value, priority_req, input ready);
  modport sink   (input valid, mode, value, priority_req, output ready);
endinterface

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  spq_pkg::val_t      out_value;
  spq_pkg::pri_t      out_priority;
  spq_pkg::occ_t      occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

/* rtl/core/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of cells, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item: mode 0 inserts value with
//   priority_req, mode 1 removes the head entry. Equal priorities leave in
//   arrival order. rsp returns exactly one item per request: status (done,
//   full, empty), the removed value and priority (zero otherwise) and the
//   number of stored entries after the operation.
//   rsp.valid rises in the cycle after acceptance. Throughput is one
//   item per cycle while rsp is being taken: every cell compares against
//   the new priority and shifts in the same cycle.
//   The response sits in an output register; req.ready is high while that
//   register is empty or being taken, so a stalled receiver holds one
//   response and then stalls the sender.
//   Reset empties the queue and drops any pending response; the cell
//   contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  cnt_t       count;
  cnt_t       count_next;
  logic       fire;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  logic       keep [DEPTH];
  val_t       cval [DEPTH];
  pri_t       cpri [DEPTH];

  assign fire  = req.valid && req.ready;
  assign full  = (count == cnt_t'(DEPTH));
  assign empty = (count == '0);
  assign req.ready = !rsp.valid || rsp.ready;

  always_comb begin
    ctrl.op      = OP_HOLD;
    ctrl.new_val = req.value;
    ctrl.new_pri = req.priority_req;
    count_next   = count;
    if (fire) begin
      if (req.mode == MODE_ENQ) begin
        if (!full) begin
          ctrl.op    = OP_ENQ;
          count_next = count + cnt_t'(1);
        end
      end else if (!empty) begin
        ctrl.op    = OP_DEQ;
        count_next = count - cnt_t'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (cnt_t'(i) < count),
      .left_keep ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_val  (cval[(i == 0) ? 0 : i - 1]),
      .left_pri  (cpri[(i == 0) ? 0 : i - 1]),
      .right_val (cval[(i == DEPTH - 1) ? i : i + 1]),
      .right_pri (cpri[(i == DEPTH - 1) ? i : i + 1]),
      .keep      (keep[i]),
      .val       (cval[i]),
      .pri       (cpri[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.occupancy    <= occ_t'(count_next);
      rsp.out_value    <= '0;
      rsp.out_priority <= '0;
      rsp.status       <= ST_DONE;
      if (req.mode == MODE_ENQ) begin
        if (full) begin
          rsp.status <= ST_FULL;
        end
      end else if (empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.out_value    <= cval[0];
        rsp.out_priority <= cpri[0];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  a_rsp_after_fire: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.valid && (rsp.occupancy == occ_t'(count)))
    else $error("response missing or occupancy mismatch");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && req.mode == MODE_ENQ && !full) |=> count == $past(count) + cnt_t'(1))
    else $error("insert did not add an entry");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= cnt_t'(2)) |-> (cpri[0] >= cpri[1]))
    else $error("head entries out of order");

endmodule

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts toward the tail on an
// insert in front of it, toward the head on a removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                left_keep,
  input  spq_pkg::val_t       left_val,
  input  spq_pkg::pri_t       left_pri,
  input  spq_pkg::val_t       right_val,
  input  spq_pkg::pri_t       right_pri,
  output logic                keep,
  output spq_pkg::val_t       val,
  output spq_pkg::pri_t       pri
);
  import spq_pkg::*;

  assign keep = occupied && (pri >= ctrl.new_pri);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ENQ: begin
        if (!keep) begin
          if (left_keep) begin
            val <= ctrl.new_val;
            pri <= ctrl.new_pri;
          end else begin
            val <= left_val;
            pri <= left_pri;
          end
        end
      end
      OP_DEQ: begin
        val <= right_val;
        pri <= right_pri;
      end
      default: begin
      end
    endcase
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue: a directed table, then
// about a thousand random enqueue/dequeue items. Each response is compared
// field by field against a typed row's outcome, else a sorted shadow queue.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int N_DIRECTED   = 24;
  localparam int RANDOM_BLKS  = 10;
  localparam int BLK_ITEMS    = 100;
  localparam int LONG_HOLD    = 60;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    status_t code;
    val_t    data;
    pri_t    prio;
    occ_t    occ;
  } outcome_t;

  typedef struct packed {
    mode_t    mode;
    val_t     data;
    pri_t     prio;
    logic     typed;
    outcome_t want;
  } stim_row_t;

  localparam outcome_t NO_TYPED = '{ST_DONE, 32'sd0, 8'd0, 4'd0};

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}},
    '{MODE_ENQ, 32'sh8000_0000,   8'd0,   1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd1}},
    '{MODE_ENQ, 32'sh7fff_ffff,   8'd255, 1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd2}},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b1, '{ST_DONE, 32'sh7fff_ffff, 8'd255, 4'd1}},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b1, '{ST_DONE, 32'sh8000_0000, 8'd0, 4'd0}},
    '{MODE_DEQ, 32'sh1234_5678,   8'd77,  1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}},
    '{MODE_ENQ, 32'sd1,           8'd10,  1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd1}},
    '{MODE_ENQ, 32'shffff_ffff,   8'd20,  1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd2}},
    '{MODE_ENQ, 32'sd3,           8'd10,  1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd3}},
    '{MODE_ENQ, 32'sh5555_5555,   8'd255, 1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd4}},
    '{MODE_ENQ, 32'shaaaa_aaaa,   8'd0,   1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd5}},
    '{MODE_ENQ, 32'sd6,           8'd20,  1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd6}},
    '{MODE_ENQ, 32'sd7,           8'd10,  1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd7}},
    '{MODE_ENQ, 32'sd8,           8'd128, 1'b1, '{ST_DONE, 32'sd0, 8'd0, 4'd8}},
    '{MODE_ENQ, 32'sh7fff_ffff,   8'd255, 1'b1, '{ST_FULL, 32'sd0, 8'd0, 4'd8}},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b0, NO_TYPED},
    '{MODE_DEQ, 32'sd0,           8'd0,   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}}
  };

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  val_t     shadow_val [DEPTH];
  pri_t     shadow_pri [DEPTH];
  int       shadow_count = 0;
  outcome_t awaited_responses [$];
  logic     typed_known;
  outcome_t typed_want;
  bit       no_idle = 1'b0;
  int       mismatches = 0;
  int       cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t apply_to_shadow_queue(mode_t m, val_t v, pri_t p);
    outcome_t res;
    int pos;
    res = '{ST_DONE, 32'sd0, 8'd0, 4'd0};
    if (m == MODE_ENQ) begin
      if (shadow_count >= DEPTH) begin
        res.code = ST_FULL;
      end else begin
        pos = shadow_count;
        while (pos > 0 && shadow_pri[pos-1] < p) begin
          shadow_val[pos] = shadow_val[pos-1];
          shadow_pri[pos] = shadow_pri[pos-1];
          pos--;
        end
        shadow_val[pos] = v;
        shadow_pri[pos] = p;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.code = ST_EMPTY;
      end else begin
        res.data = shadow_val[0];
        res.prio = shadow_pri[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_val[k-1] = shadow_val[k];
          shadow_pri[k-1] = shadow_pri[k];
        end
        shadow_count--;
      end
    end
    res.occ = occ_t'(shadow_count);
    return res;
  endfunction

  task automatic flag_field(input string field, input logic signed [63:0] want,
                            input logic signed [63:0] got);
    $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch_channels
    outcome_t got;
    outcome_t want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      got = apply_to_shadow_queue(mode_t'(req_ch.mode), req_ch.value,
                                  req_ch.priority_req);
      awaited_responses.push_back(typed_known ? typed_want : got);
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_responses.size() == 0) begin
        $display("%0t ns: response expected none actual status %0d value %0d",
                 $time, rsp_ch.status, rsp_ch.out_value);
        mismatches++;
      end else begin
        want = awaited_responses.pop_front();
        if (rsp_ch.status !== want.code)
          flag_field("status", want.code, rsp_ch.status);
        if (rsp_ch.out_value !== want.data)
          flag_field("out_value", want.data, rsp_ch.out_value);
        if (rsp_ch.out_priority !== want.prio)
          flag_field("out_priority", want.prio, rsp_ch.out_priority);
        if (rsp_ch.occupancy !== want.occ)
          flag_field("occupancy", want.occ, rsp_ch.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : drain_side
    int stall;
    int taken;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(5);
      if (taken == 350 || taken == 750)
        stall = LONG_HOLD;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
    end
  end

  task automatic offer_item(input mode_t m, input val_t v, input pri_t p,
                            input logic typed, input outcome_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= m;
    req_ch.value        <= v;
    req_ch.priority_req <= p;
    typed_known         <= typed;
    typed_want          <= want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_responses.size() != 0);
  endtask

  initial begin : feed_side
    int   enq_pct;
    mode_t m;
    val_t  v;
    pri_t  p;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= MODE_ENQ;
    req_ch.value        <= 32'sd0;
    req_ch.priority_req <= 8'd0;
    typed_known         <= 1'b0;
    typed_want          <= NO_TYPED;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      offer_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].prio,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    hold_until_drained();

    for (int blk = 0; blk < RANDOM_BLKS; blk++) begin
      no_idle = (blk % 4 == 3);
      enq_pct = (blk % 3 == 0) ? 50 : (blk % 3 == 1) ? 70 : 30;
      if (blk == 5)
        hold_until_drained();
      repeat (BLK_ITEMS) begin
        m = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        case ($urandom_range(3))
          0:       p = pri_t'($urandom_range(3));
          1:       p = $urandom_range(1) ? 8'd255 : 8'd0;
          default: p = pri_t'($urandom_range(255));
        endcase
        case ($urandom_range(11))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = 32'shffff_ffff;
          default: v = val_t'($urandom());
        endcase
        offer_item(m, v, p, 1'b0, NO_TYPED);
      end
    end
    no_idle = 1'b0;
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_responses.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
